[rtl/hsfc_pkg.sv]
// Shared constants and types for the half/single float converter.
`timescale 1ns / 1ps
`default_nettype none
package hsfc_pkg;
	localparam logic [30:0] SglInf     = 31'h7f800000;
	localparam logic [30:0] SglMaxHalf = 31'h477fe000;
	localparam logic [30:0] SglMinHalf = 31'h38800000;
	localparam logic [30:0] SglMinNan  = 31'h7f802000;
	localparam logic [17:0] BiasDelta  = 18'h1c000;
	localparam logic [15:0] HalfInf    = 16'h7c00;
	localparam logic [15:0] HalfQnan   = 16'h7c01;
	localparam logic [4:0]  ShFlush    = 5'd31;

	typedef enum logic [4:0] {
		CLS_SUB  = 5'b00001,
		CLS_NORM = 5'b00010,
		CLS_INF  = 5'b00100,
		CLS_NANZ = 5'b01000,
		CLS_NAN  = 5'b10000
	} s2h_cls_t;

	typedef enum logic [1:0] {
		HCLS_ZERO = 2'd0,
		HCLS_SUB  = 2'd1,
		HCLS_NORM = 2'd2,
		HCLS_SPEC = 2'd3
	} h2s_cls_t;

	// first-stage decode of one word
	typedef struct packed {
		logic        kind;
		logic        sgn;
		s2h_cls_t    cls;
		logic [14:0] hbits;  // half candidate for normal and NaN paths
		logic [23:0] sig;    // single significand with hidden bit
		logic [4:0]  sh;     // subnormal shift, ShFlush = flush
		logic [9:0]  hmag;   // half mantissa (half to single)
		h2s_cls_t    hcls;   // zero, subnormal, normal, inf/nan
		logic [4:0]  hexp;
	} dec_t;
endpackage
`default_nettype wire

[rtl/hsfc_if.sv]
// Valid/ready channel carrying one word of payload.
`timescale 1ns / 1ps
`default_nettype none
interface hsfc_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/hsfc_decode.sv]
// Stage one logic: classify the operand for either direction.
`timescale 1ns / 1ps
`default_nettype none
module hsfc_decode import hsfc_pkg::*; (
	input  wire logic        kind,
	input  wire logic [31:0] operand,
	output dec_t             dec
);
	logic [30:0] mag;
	logic [7:0]  e;
	logic [7:0]  shw;
	logic [17:0] nb;
	logic [14:0] hm;
	assign mag = operand[30:0];
	assign e   = mag[30:23];
	assign shw = 8'd126 - e;
	assign nb  = mag[30:13] - BiasDelta;
	assign hm  = operand[14:0];
	always_comb begin
		dec.kind = kind;
		dec.sgn  = kind ? operand[15] : operand[31];
		dec.sig  = {1'b1, mag[22:0]};
		dec.sh   = (e == 8'd0 || shw >= 8'd24) ? ShFlush : shw[4:0];
		if (mag < SglMinHalf) begin
			dec.cls = CLS_SUB;
		end else if (mag <= SglMaxHalf) begin
			dec.cls = CLS_NORM;
		end else if (mag <= SglInf) begin
			dec.cls = CLS_INF;
		end else if (mag < SglMinNan) begin
			dec.cls = CLS_NANZ;
		end else begin
			dec.cls = CLS_NAN;
		end
		// NaN: exponent 0xff is replaced by half exponent 0x1f over the top mantissa bits
		dec.hbits = (dec.cls == CLS_NAN) ? {5'h1f, mag[22:13]} : nb[14:0];
		dec.hmag  = hm[9:0];
		dec.hexp  = hm[14:10];
		if (hm >= 15'h7c00) begin
			dec.hcls = HCLS_SPEC;
		end else if (hm >= 15'h0400) begin
			dec.hcls = HCLS_NORM;
		end else if (hm == 15'd0) begin
			dec.hcls = HCLS_ZERO;
		end else begin
			dec.hcls = HCLS_SUB;
		end
	end
endmodule
`default_nettype wire

[rtl/hsfc_shift.sv]
// Stage two logic: subnormal shifts and result selection for both directions.
`timescale 1ns / 1ps
`default_nettype none
module hsfc_shift import hsfc_pkg::*; (
	input  wire dec_t        dec,
	output logic [15:0]      half,
	output logic [31:0]      single
);
	logic [23:0] sub;
	logic [3:0]  p;
	logic [22:0] nfr;
	assign sub = (dec.sh == ShFlush) ? 24'd0 : (dec.sig >> dec.sh);
	always_comb begin
		p = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (dec.hmag[i]) begin
				p = 4'(i);
			end
		end
	end
	assign nfr = 23'({dec.hmag, 13'd0} << (4'd10 - p));
	always_comb begin
		case (dec.cls)
			CLS_SUB:  half = {dec.sgn, 15'(sub)};
			CLS_NORM: half = {dec.sgn, dec.hbits};
			CLS_INF:  half = {dec.sgn, HalfInf[14:0]};
			CLS_NANZ: half = {dec.sgn, HalfQnan[14:0]};
			CLS_NAN:  half = {dec.sgn, dec.hbits};
			default:  half = 16'd0;
		endcase
		case (dec.hcls)
			HCLS_ZERO: single = {dec.sgn, 31'd0};
			HCLS_SUB:  single = {dec.sgn, 8'(8'd103 + 8'(p)), nfr};
			HCLS_NORM: single = {dec.sgn, 8'(8'd112 + 8'(dec.hexp)), dec.hmag, 13'd0};
			default:   single = {dec.sgn, 8'hff, dec.hmag, 13'd0};
		endcase
	end
endmodule
`default_nettype wire

[rtl/half_single_float_converter.sv]
// Top level of the half/single float converter pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Converts one IEEE word per cycle between binary32 and binary16 while the
// output is drained (kind 0: single to half, truncating, half in the low 16
// bits; kind 1: half in low 16 bits to exact single). Three register stages:
// decode, shift/select, output. A stall holds a stage only while it and
// every later stage hold a valid word, so bubbles are squeezed out.
module half_single_float_converter import hsfc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	hsfc_if.sink     in_ch,
	hsfc_if.source   out_ch
);
	dec_t        dec;
	dec_t        dec_s1;
	logic        v_s1, v_s2, v_s3;
	logic        kind_s2;
	logic [15:0] half;
	logic [31:0] single;
	logic [15:0] half_s2;
	logic [31:0] single_s2;
	logic [31:0] res_s3;
	logic        adv3, adv2, adv1;

	hsfc_decode u_dec (.kind(in_ch.data.kind), .operand(in_ch.data.operand), .dec(dec));
	hsfc_shift u_sh (.dec(dec_s1), .half(half), .single(single));

	assign adv3 = !v_s3 || out_ch.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ch.ready = adv1;
	assign out_ch.valid = v_s3;
	assign out_ch.data.converted = res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_ch.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) dec_s1 <= dec;
		if (adv2) begin
			kind_s2   <= dec_s1.kind;
			half_s2   <= half;
			single_s2 <= single;
		end
		if (adv3) res_s3 <= kind_s2 ? single_s2 : {16'd0, half_s2};
	end
endmodule
`default_nettype wire

[tb/hsfc_tb_types.sv]
// Word types carried on the converter's input and output channels.
`timescale 1ns / 1ps
package hsfc_tb_types;
	typedef struct packed {
		logic        kind;
		logic [31:0] operand;
	} conv_req_t;

	typedef struct packed {
		logic [31:0] converted;
	} conv_res_t;

	localparam logic KIND_S2H = 1'b0;
	localparam logic KIND_H2S = 1'b1;
endpackage

[tb/half_single_float_converter_tb.sv]
// Self-checking bench for the half/single float converter.
`timescale 1ns / 1ps
module half_single_float_converter_tb;
	import hsfc_pkg::*;
	import hsfc_tb_types::*;

	logic clk;
	logic arst_n;

	hsfc_if #(.payload_t(conv_req_t)) in_ch ();
	hsfc_if #(.payload_t(conv_res_t)) out_ch ();

	half_single_float_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	conv_req_t   pending_q[$];
	conv_res_t   converted_q[$];
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned rx_hold;
	bit          tx_busy;
	bit          tx_pause;
	int unsigned errors;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [15:0] to_half(input logic [31:0] x);
		logic [30:0] mag;
		logic [7:0]  e;
		logic [23:0] sig;
		logic [31:0] h;
		int unsigned sh;
		mag = x[30:0];
		if (mag < SglMinHalf) begin
			e = mag[30:23];
			if (e == 8'd0) begin
				h = 32'd0;
			end else begin
				sig = {1'b1, mag[22:0]};
				sh  = 126 - e;
				h   = (sh >= 24) ? 32'd0 : (32'(sig) >> sh);
			end
		end else if (mag <= SglMaxHalf) begin
			h = (32'(mag) >> 13) - 32'h1c000;
		end else if (mag <= SglInf) begin
			h = 32'h7c00;
		end else if (mag < SglMinNan) begin
			h = 32'h7c01;
		end else begin
			h = (32'(mag) >> 13) - 32'h38000;
		end
		return h[15:0] | {x[31], 15'd0};
	endfunction

	function automatic logic [31:0] to_single(input logic [15:0] v);
		logic [14:0] mag;
		logic [31:0] r;
		int          p;
		mag = v[14:0];
		if (mag >= 15'h7c00) begin
			r = 32'h7f800000 | (32'(mag[9:0]) << 13);
		end else if (mag >= 15'h0400) begin
			r = (32'(mag) + 32'h1c000) << 13;
		end else if (mag == 15'd0) begin
			r = 32'd0;
		end else begin
			p = 9;
			while (mag[p] == 1'b0)
				p--;
			r = (32'(p + 103) << 23) | ((32'(mag) << (23 - p)) & 32'h7fffff);
		end
		return r | {v[15], 31'd0};
	endfunction

	function automatic conv_res_t convert(input conv_req_t w);
		conv_res_t res;
		if (w.kind == KIND_S2H)
			res.converted = {16'd0, to_half(w.operand)};
		else
			res.converted = to_single(w.operand[15:0]);
		return res;
	endfunction

	// accept side: record expectations and check results
	always @(posedge clk) begin
		conv_res_t want;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			converted_q.push_back(convert(in_ch.data));
			tx_busy = 1'b0;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (converted_q.size() == 0) begin
				$error("converted: unexpected word %h", out_ch.data.converted);
				errors++;
			end else begin
				want = converted_q.pop_front();
				if (out_ch.data.converted !== want.converted) begin
					$error("converted: expected %h actual %h", want.converted,
						out_ch.data.converted);
					errors++;
				end
			end
		end
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!tx_busy) begin
			if (!tx_pause && pending_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_ch.data  <= pending_q.pop_front();
				in_ch.valid <= 1'b1;
				tx_busy = 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic conv_req_t rand_word();
		conv_req_t w;
		logic [31:0] r;
		r = $urandom();
		w.kind = 1'($urandom_range(1));
		case ($urandom_range(7))
			0: r[30:0] = 31'(SglMaxHalf + $urandom_range(3) - 1);
			1: r[30:0] = 31'(SglMinHalf + $urandom_range(3) - 1);
			2: r[30:23] = 8'hff;
			3: r[30:0] = {8'hff, 10'd0, r[12:0]};
			4: r[30:23] = 8'(8'd103 + $urandom_range(24));
			5: r[14:10] = $urandom_range(1) ? 5'h1f : 5'h00;
			default: ;
		endcase
		w.operand = r;
		return w;
	endfunction

	task automatic add(input logic kind, input logic [31:0] op);
		conv_req_t w;
		w.kind    = kind;
		w.operand = op;
		pending_q.push_back(w);
	endtask

	task automatic drain();
		wait (pending_q.size() == 0 && !tx_busy && converted_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
		tx_busy      = 1'b0;
		tx_pause     = 1'b0;
		rx_hold      = 0;
		errors       = 0;
		tx_idle_pct  = 37;
		rx_idle_pct  = 54;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zeros, limits, overflow edge, NaN payloads, subnormals
		add(KIND_S2H, 32'h00000000);
		add(KIND_S2H, 32'h80000000);
		add(KIND_S2H, 32'hffffffff);
		add(KIND_S2H, 32'h477fe000);
		add(KIND_S2H, 32'h477fe001);
		add(KIND_S2H, 32'hff7fffff);
		add(KIND_S2H, 32'h7f800000);
		add(KIND_S2H, 32'hff800001);
		add(KIND_S2H, 32'h7f801fff);
		add(KIND_S2H, 32'h7f802000);
		add(KIND_S2H, 32'h38800000);
		add(KIND_S2H, 32'h387fffff);
		add(KIND_S2H, 32'h33800000);
		add(KIND_S2H, 32'h337fffff);
		add(KIND_S2H, 32'h007fffff);
		add(KIND_H2S, 32'hffff0000);
		add(KIND_H2S, 32'h00008000);
		add(KIND_H2S, 32'h00000001);
		add(KIND_H2S, 32'h000003ff);
		add(KIND_H2S, 32'h12340400);
		add(KIND_H2S, 32'h00007bff);
		add(KIND_H2S, 32'hffff7c00);
		add(KIND_H2S, 32'h0000fc01);
		add(KIND_H2S, 32'h00007fff);
		repeat (460) pending_q.push_back(rand_word());
		drain();

		tx_idle_pct = 54;
		rx_idle_pct = 37;
		repeat (480) pending_q.push_back(rand_word());
		drain();

		// stall the output long enough to back the pipeline up
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold     = 200;
		repeat (480) pending_q.push_back(rand_word());
		wait (pending_q.size() < 240);
		tx_pause = 1'b1;
		wait (!tx_busy && converted_q.size() == 0);
		repeat (10) @(posedge clk);
		tx_pause = 1'b0;
		drain();

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[filelist.f]
rtl/hsfc_pkg.sv
rtl/hsfc_if.sv
rtl/hsfc_decode.sv
rtl/hsfc_shift.sv
rtl/half_single_float_converter.sv
tb/hsfc_tb_types.sv
tb/half_single_float_converter_tb.sv
